@@ design/bhr_pkg.sv @@
package bhr_pkg;

    localparam int NUM_RELAYS_DEF = 6;
    localparam int OUT_RELAYS_W = 6;

    localparam int HOLD_W = 8;
    localparam int LIMIT_W = 8;
    localparam int PHASE_W = 3;

    localparam logic [HOLD_W-1:0] HOLD_FOLD_ABOVE = 8'd200;
    localparam logic [HOLD_W-1:0] HOLD_FOLD_TO = 8'd151;
    localparam int BLINK_PERIOD = 5;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BLINK_PERIOD - 1);
    localparam logic [PHASE_W-1:0] PHASE_FOLD = PHASE_W'(151 % BLINK_PERIOD);

    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 8'd10;
    localparam logic [LIMIT_W-1:0] RESTART_LIMIT_RST = 8'd50;
    localparam logic [LIMIT_W-1:0] AP_LIMIT_RST = 8'd100;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RESTART_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AP_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_SET     = 2'd2
    } t_action;

    typedef struct packed {
        logic [LIMIT_W-1:0] short_press_limit;
        logic [LIMIT_W-1:0] restart_limit;
        logic [LIMIT_W-1:0] ap_limit;
    } t_cfg;

    typedef struct packed {
        logic [OUT_RELAYS_W-1:0] relays;
        logic                    led_on;
        logic [OUT_RELAYS_W-1:0] relays_changed;
        logic                    restart_request;
        logic                    ap_request;
        logic                    smartlink_request;
        logic                    quicklink_pulse;
    } t_result;

endpackage

@@ design/bhr_cfg_regs.sv @@
module bhr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhr_pkg::PADDR_W-1:0]  paddr,
    input  logic [bhr_pkg::PDATA_W-1:0]  pwdata,
    output logic [bhr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bhr_pkg::t_cfg                o_cfg
);

    bhr_pkg::t_cfg r_cfg;
    logic [bhr_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[bhr_pkg::PADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press_limit <= bhr_pkg::SHORT_LIMIT_RST;
            r_cfg.restart_limit <= bhr_pkg::RESTART_LIMIT_RST;
            r_cfg.ap_limit <= bhr_pkg::AP_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bhr_pkg::REG_SHORT_LIMIT: begin
                    r_cfg.short_press_limit <= pwdata[bhr_pkg::LIMIT_W-1:0];
                end
                bhr_pkg::REG_RESTART_LIMIT: begin
                    r_cfg.restart_limit <= pwdata[bhr_pkg::LIMIT_W-1:0];
                end
                bhr_pkg::REG_AP_LIMIT: begin
                    r_cfg.ap_limit <= pwdata[bhr_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            bhr_pkg::REG_SHORT_LIMIT: begin
                prdata[bhr_pkg::LIMIT_W-1:0] = r_cfg.short_press_limit;
            end
            bhr_pkg::REG_RESTART_LIMIT: begin
                prdata[bhr_pkg::LIMIT_W-1:0] = r_cfg.restart_limit;
            end
            bhr_pkg::REG_AP_LIMIT: begin
                prdata[bhr_pkg::LIMIT_W-1:0] = r_cfg.ap_limit;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

@@ design/bhr_core.sv @@
module bhr_core #(
    parameter int NUM_RELAYS = bhr_pkg::NUM_RELAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_action,
    input  logic               i_key_down,
    input  logic [2:0]         i_relay_index,
    input  logic               i_relay_value,
    input  bhr_pkg::t_cfg      i_cfg,
    output bhr_pkg::t_result   o_result
);

    logic [bhr_pkg::HOLD_W-1:0]  r_hold, n_hold;
    logic [bhr_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [NUM_RELAYS-1:0]       r_relay, n_relay;
    logic                        r_led, n_led;

    logic [bhr_pkg::HOLD_W-1:0]  hold_inc;
    logic [bhr_pkg::PHASE_W-1:0] phase_inc;
    logic [NUM_RELAYS-1:0]       sel;
    logic [NUM_RELAYS-1:0]       changed;
    logic                        all_val;
    logic                        restart, ap, smart, quick;

    assign hold_inc = r_hold + bhr_pkg::HOLD_W'(1);
    assign phase_inc = (r_phase == bhr_pkg::PHASE_LAST) ? '0
                     : r_phase + bhr_pkg::PHASE_W'(1);
    assign all_val = (r_relay == '0);

    // one-hot relay select, empty when the index is out of range
    always_comb begin
        for (int i = 0; i < NUM_RELAYS; i++) begin
            sel[i] = (int'(i_relay_index) == i);
        end
    end

    always_comb begin
        n_hold = r_hold;
        n_phase = r_phase;
        n_relay = r_relay;
        n_led = r_led;
        changed = '0;
        restart = 1'b0;
        ap = 1'b0;
        smart = 1'b0;
        quick = 1'b0;
        case (bhr_pkg::t_action'(i_action))
            bhr_pkg::ACT_TICK: begin
                if (i_key_down) begin
                    if (hold_inc > bhr_pkg::HOLD_FOLD_ABOVE) begin
                        n_hold = bhr_pkg::HOLD_FOLD_TO;
                        n_phase = bhr_pkg::PHASE_FOLD;
                    end else begin
                        n_hold = hold_inc;
                        n_phase = phase_inc;
                        if (hold_inc >= i_cfg.ap_limit) begin
                            quick = 1'b1;
                        end else if (hold_inc >= i_cfg.restart_limit
                                     && phase_inc == '0) begin
                            n_led = ~r_led;
                        end
                    end
                end else begin
                    n_hold = '0;
                    n_phase = '0;
                    if (r_relay == '0) begin
                        n_led = 1'b0;
                    end
                end
            end
            bhr_pkg::ACT_RELEASE: begin
                if (r_hold == '0) begin
                end else if (r_hold < i_cfg.short_press_limit) begin
                    n_relay = all_val ? '1 : '0;
                    changed = '1;
                    n_led = all_val;
                end else if (r_hold < i_cfg.restart_limit) begin
                    restart = 1'b1;
                end else if (r_hold < i_cfg.ap_limit) begin
                    ap = 1'b1;
                end else begin
                    smart = 1'b1;
                end
                n_hold = '0;
                n_phase = '0;
            end
            bhr_pkg::ACT_SET: begin
                if (sel != '0) begin
                    n_relay = i_relay_value ? (r_relay | sel) : (r_relay & ~sel);
                    changed = sel;
                    n_led = (n_relay != '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_phase <= '0;
            r_relay <= '0;
            r_led <= 1'b0;
        end else if (i_accept) begin
            r_hold <= n_hold;
            r_phase <= n_phase;
            r_relay <= n_relay;
            r_led <= n_led;
        end
    end

    // only relays 0 to 5 are shown
    for (genvar g = 0; g < bhr_pkg::OUT_RELAYS_W; g++) begin : g_out
        if (g < NUM_RELAYS) begin : g_used
            assign o_result.relays[g] = n_relay[g];
            assign o_result.relays_changed[g] = changed[g];
        end else begin : g_unused
            assign o_result.relays[g] = 1'b0;
            assign o_result.relays_changed[g] = 1'b0;
        end
    end

    assign o_result.led_on = n_led;
    assign o_result.restart_request = restart;
    assign o_result.ap_request = ap;
    assign o_result.smartlink_request = smart;
    assign o_result.quicklink_pulse = quick;

endmodule

@@ design/button_hold_relay_controller_unit.sv @@
// Relay strip controller for one push button. Each input beat is a tick carrying the
// button level, a release edge, or a command setting one relay; each accepted beat
// yields exactly one result beat, registered and shown in the cycle after acceptance.
// A new beat is taken every cycle while the result register is empty or being
// drained, so the sustained rate is one item per clock; the hold counter and relay
// bank state update on each accepted beat. Limits are written over the APB port at
// byte addresses 0, 4 and 8; no clearing pass is needed after reset.
module button_hold_relay_controller_unit #(
    parameter int NUM_RELAYS = bhr_pkg::NUM_RELAYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhr_pkg::PADDR_W-1:0]  paddr,
    input  logic [bhr_pkg::PDATA_W-1:0]  pwdata,
    output logic [bhr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic                         i_key_down,
    input  logic [2:0]                   i_relay_index,
    input  logic                         i_relay_value,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [5:0]                   o_relays,
    output logic                         o_led_on,
    output logic [5:0]                   o_relays_changed,
    output logic                         o_restart_request,
    output logic                         o_ap_request,
    output logic                         o_smartlink_request,
    output logic                         o_quicklink_pulse
);

    bhr_pkg::t_cfg    cfg;
    bhr_pkg::t_result result;
    bhr_pkg::t_result r_result;
    logic             r_out_valid;
    logic             accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept = i_in_valid && o_in_ready;

    bhr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bhr_core #(
        .NUM_RELAYS (NUM_RELAYS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_key_down    (i_key_down),
        .i_relay_index (i_relay_index),
        .i_relay_value (i_relay_value),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_relays = r_result.relays;
    assign o_led_on = r_result.led_on;
    assign o_relays_changed = r_result.relays_changed;
    assign o_restart_request = r_result.restart_request;
    assign o_ap_request = r_result.ap_request;
    assign o_smartlink_request = r_result.smartlink_request;
    assign o_quicklink_pulse = r_result.quicklink_pulse;

endmodule

@@ tb/button_hold_relay_controller_unit_tb.sv @@
module button_hold_relay_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int SECTION_BEATS = 225;

    class strip_checker;
        bhr_pkg::t_result awaited_beats[$];
        logic [bhr_pkg::LIMIT_W-1:0] short_lim;
        logic [bhr_pkg::LIMIT_W-1:0] restart_lim;
        logic [bhr_pkg::LIMIT_W-1:0] ap_lim;
        logic [bhr_pkg::HOLD_W-1:0] hold_cnt;
        logic [bhr_pkg::OUT_RELAYS_W-1:0] relay_bits;
        logic led;
        int n_mismatch;
        int n_checked;
        int n_short;
        int n_restart;
        int n_ap;
        int n_smart;
        int n_quick;
        int n_blink;
        int n_fold;

        function new();
            short_lim = bhr_pkg::SHORT_LIMIT_RST;
            restart_lim = bhr_pkg::RESTART_LIMIT_RST;
            ap_lim = bhr_pkg::AP_LIMIT_RST;
            hold_cnt = '0;
            relay_bits = '0;
            led = 1'b0;
            n_mismatch = 0;
            n_checked = 0;
            n_short = 0;
            n_restart = 0;
            n_ap = 0;
            n_smart = 0;
            n_quick = 0;
            n_blink = 0;
            n_fold = 0;
        endfunction

        function void set_limit(logic [bhr_pkg::REG_IDX_W-1:0] idx,
                                logic [bhr_pkg::LIMIT_W-1:0] value);
            case (idx)
                bhr_pkg::REG_SHORT_LIMIT: short_lim = value;
                bhr_pkg::REG_RESTART_LIMIT: restart_lim = value;
                bhr_pkg::REG_AP_LIMIT: ap_lim = value;
                default: ;
            endcase
        endfunction

        // advance the strip state by one command beat and queue the result it yields
        function void take_command(logic [1:0] act, logic key, logic [2:0] idx, logic val);
            bhr_pkg::t_result r;
            r = '0;
            case (act)
                bhr_pkg::ACT_TICK: begin
                    if (key) begin
                        hold_cnt = hold_cnt + 8'd1;
                        if (hold_cnt > bhr_pkg::HOLD_FOLD_ABOVE) begin
                            hold_cnt = bhr_pkg::HOLD_FOLD_TO;
                            n_fold++;
                        end else if (hold_cnt >= ap_lim) begin
                            r.quicklink_pulse = 1'b1;
                            n_quick++;
                        end else if (hold_cnt >= restart_lim
                                     && int'(hold_cnt) % bhr_pkg::BLINK_PERIOD == 0) begin
                            led = ~led;
                            n_blink++;
                        end
                    end else begin
                        hold_cnt = '0;
                        if (relay_bits == '0)
                            led = 1'b0;
                    end
                end
                bhr_pkg::ACT_RELEASE: begin
                    if (hold_cnt != '0) begin
                        if (hold_cnt < short_lim) begin
                            relay_bits = (relay_bits != '0) ? '0 : '1;
                            r.relays_changed = '1;
                            led = (relay_bits != '0);
                            n_short++;
                        end else if (hold_cnt < restart_lim) begin
                            r.restart_request = 1'b1;
                            n_restart++;
                        end else if (hold_cnt < ap_lim) begin
                            r.ap_request = 1'b1;
                            n_ap++;
                        end else begin
                            r.smartlink_request = 1'b1;
                            n_smart++;
                        end
                    end
                    hold_cnt = '0;
                end
                bhr_pkg::ACT_SET: begin
                    if (int'(idx) < bhr_pkg::NUM_RELAYS_DEF) begin
                        relay_bits[idx] = val;
                        r.relays_changed[idx] = 1'b1;
                        led = (relay_bits != '0);
                    end
                end
                default: ;
            endcase
            r.relays = relay_bits;
            r.led_on = led;
            awaited_beats.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns mismatch: %s", $time, what);
            n_mismatch++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s is %0d, expected %0d (result %0d)",
                                          name, got, want, n_checked));
        endtask

        task match_result(bhr_pkg::t_result got);
            bhr_pkg::t_result want;
            if (awaited_beats.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
                return;
            end
            want = awaited_beats.pop_front();
            compare_field("relays", int'(got.relays), int'(want.relays));
            compare_field("led_on", int'(got.led_on), int'(want.led_on));
            compare_field("relays_changed", int'(got.relays_changed),
                          int'(want.relays_changed));
            compare_field("restart_request", int'(got.restart_request),
                          int'(want.restart_request));
            compare_field("ap_request", int'(got.ap_request), int'(want.ap_request));
            compare_field("smartlink_request", int'(got.smartlink_request),
                          int'(want.smartlink_request));
            compare_field("quicklink_pulse", int'(got.quicklink_pulse),
                          int'(want.quicklink_pulse));
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bhr_pkg::PADDR_W-1:0] paddr;
    logic [bhr_pkg::PDATA_W-1:0] pwdata;
    logic [bhr_pkg::PDATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_action;
    logic i_key_down;
    logic [2:0] i_relay_index;
    logic i_relay_value;
    logic o_out_valid;
    logic i_out_ready;
    logic [5:0] o_relays;
    logic o_led_on;
    logic [5:0] o_relays_changed;
    logic o_restart_request;
    logic o_ap_request;
    logic o_smartlink_request;
    logic o_quicklink_pulse;

    strip_checker strip = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_cnt = 0;
    int n_beats = 0;
    int n_useful = 0;
    int limit_sets[6][3] = '{'{10, 50, 100}, '{1, 1, 1}, '{255, 255, 255},
                             '{30, 12, 0}, '{5, 20, 40}, '{8, 60, 200}};

    button_hold_relay_controller_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_key_down(i_key_down),
        .i_relay_index(i_relay_index),
        .i_relay_value(i_relay_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_relays(o_relays),
        .o_led_on(o_led_on),
        .o_relays_changed(o_relays_changed),
        .o_restart_request(o_restart_request),
        .o_ap_request(o_ap_request),
        .o_smartlink_request(o_smartlink_request),
        .o_quicklink_pulse(o_quicklink_pulse)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                strip.match_result(bhr_pkg::t_result'{
                    relays: o_relays,
                    led_on: o_led_on,
                    relays_changed: o_relays_changed,
                    restart_request: o_restart_request,
                    ap_request: o_ap_request,
                    smartlink_request: o_smartlink_request,
                    quicklink_pulse: o_quicklink_pulse
                });
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("button_hold_relay_controller_unit_tb: FAIL");
        $finish;
    end

    task automatic send_item(input logic [1:0] act, input logic key,
                             input logic [2:0] idx, input logic val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_key_down <= key;
        i_relay_index <= idx;
        i_relay_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        strip.take_command(act, key, idx, val);
        n_beats++;
        if (act != ACT_UNUSED
            && !(act == bhr_pkg::ACT_SET && int'(idx) >= bhr_pkg::NUM_RELAYS_DEF))
            n_useful++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                  3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [bhr_pkg::REG_IDX_W-1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bhr_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= bhr_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        strip.set_limit(idx, bhr_pkg::LIMIT_W'(value));
    endtask

    task automatic set_limits(input int s, input int r, input int a);
        write_reg(bhr_pkg::REG_SHORT_LIMIT, s);
        write_reg(bhr_pkg::REG_RESTART_LIMIT, r);
        write_reg(bhr_pkg::REG_AP_LIMIT, a);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (strip.awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_ticks(input int n);
        repeat (n)
            send_item(bhr_pkg::ACT_TICK, 1'b1, 3'($urandom_range(7)),
                      1'($urandom_range(1)));
    endtask

    // presses of random length clustered round the limits, with a few fold-backs
    task automatic random_section(input int quota);
        int start;
        int k;
        int base;
        int len;
        start = n_useful;
        while (n_useful - start < quota) begin
            if ($urandom_range(3) == 0) begin
                send_noise();
            end else begin
                k = $urandom_range(19);
                if (k == 0) begin
                    len = $urandom_range(240, 200);
                end else if (k < 5) begin
                    len = $urandom_range(12, 1);
                end else begin
                    case (k % 3)
                        0: base = int'(strip.short_lim);
                        1: base = int'(strip.restart_lim);
                        default: base = int'(strip.ap_lim);
                    endcase
                    len = base + int'($urandom_range(4)) - 2;
                    if (len < 1)
                        len = 1;
                    if (len > 210)
                        len = 210;
                end
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(24) == 0)
                        send_item(bhr_pkg::ACT_SET, 1'($urandom_range(1)),
                                  3'($urandom_range(7)), 1'($urandom_range(1)));
                    if ($urandom_range(199) == 0)
                        send_noise();
                    hold_ticks(1);
                end
                k = $urandom_range(9);
                if (k >= 8)
                    send_item(bhr_pkg::ACT_TICK, 1'b0, 3'($urandom_range(7)),
                              1'($urandom_range(1)));
                if (k != 9)
                    send_item(bhr_pkg::ACT_RELEASE, 1'($urandom_range(1)),
                              3'($urandom_range(7)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_action = bhr_pkg::ACT_TICK;
        i_key_down = 1'b0;
        i_relay_index = '0;
        i_relay_value = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 82;

        // tight limits so every release class is reached in a few beats
        set_limits(2, 3, 6);
        send_item(bhr_pkg::ACT_TICK, 1'b0, 3'd7, 1'b1);
        send_item(bhr_pkg::ACT_RELEASE, 1'b0, 3'd0, 1'b0);
        send_item(ACT_UNUSED, 1'b1, 3'd7, 1'b1);
        send_item(bhr_pkg::ACT_SET, 1'b0, 3'd7, 1'b1);
        send_item(bhr_pkg::ACT_SET, 1'b1, 3'd5, 1'b1);
        hold_ticks(1);
        send_item(bhr_pkg::ACT_RELEASE, 1'b1, 3'd7, 1'b1);
        hold_ticks(1);
        send_item(bhr_pkg::ACT_RELEASE, 1'b0, 3'd0, 1'b0);
        hold_ticks(2);
        send_item(bhr_pkg::ACT_RELEASE, 1'b0, 3'd3, 1'b1);
        hold_ticks(5);
        send_item(bhr_pkg::ACT_RELEASE, 1'b1, 3'd4, 1'b0);
        hold_ticks(6);
        send_item(bhr_pkg::ACT_RELEASE, 1'b0, 3'd6, 1'b1);
        send_item(bhr_pkg::ACT_SET, 1'b0, 3'd5, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int sec = 0; sec < 2; sec++) begin
                set_limits(limit_sets[2*phase+sec][0], limit_sets[2*phase+sec][1],
                           limit_sets[2*phase+sec][2]);
                random_section(SECTION_BEATS);
                wait_idle();
            end
        end
        repeat (8) @(posedge i_clk);

        if (strip.awaited_beats.size() != 0)
            strip.report_mismatch("results still outstanding at the end");
        $display("covered %0d command beats (%0d effective), %0d results checked, %s",
                 n_beats, n_useful, strip.n_checked, "seven limit settings");
        $display("releases %0d short, %0d restart, %0d ap, %0d smart-link; %s",
                 strip.n_short, strip.n_restart, strip.n_ap, strip.n_smart,
                 $sformatf("%0d quick-link, %0d blink, %0d fold",
                           strip.n_quick, strip.n_blink, strip.n_fold));
        if (strip.n_mismatch == 0) begin
            $display("button_hold_relay_controller_unit_tb: PASS");
        end else begin
            $display("button_hold_relay_controller_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
